[sv/kqml_pkg.sv]
package kqml_pkg;

    localparam int QUEUE_DEPTH = 32;

    typedef enum logic [1:0] {
        REQ_KEY    = 2'd0,
        REQ_VBLANK = 2'd1,
        REQ_READ   = 2'd2,
        REQ_WRITE  = 2'd3
    } req_kind_t;

    localparam logic [8:0] ADDR_CLEAR    = 9'h000;
    localparam logic [8:0] ADDR_POP      = 9'h002;
    localparam logic [8:0] ADDR_MOUSE_HI = 9'h020;
    localparam logic [8:0] ADDR_MOUSE_LO = 9'h021;
    localparam logic [8:0] ADDR_KEYS_LO  = 9'h040;
    localparam logic [8:0] ADDR_KEYS_HI  = 9'h13F;

    localparam int         KEYMAP_SIZE   = 100;
    localparam logic [5:0] MAG_LIMIT     = 6'd63;

    localparam logic [7:0] KEYMAP [0:KEYMAP_SIZE-1] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21,
        8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
        8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C,
        8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B,
        8'h00, 8'h27, 8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h3A, 8'h3B, 8'h3C,
        8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h57, 8'h58,
        8'h00, 8'h46, 8'h00, 8'hD2, 8'hC7, 8'hC9, 8'hD3, 8'hCF, 8'hD1, 8'hCD,
        8'hCB, 8'hD0, 8'hC8, 8'h45, 8'hB5, 8'h37, 8'h4A, 8'h4E, 8'h9C, 8'h4F,
        8'h50, 8'h51, 8'h4B, 8'h4C, 8'h4D, 8'h47, 8'h48, 8'h49, 8'h52, 8'h53
    };

    // modifier keys and mute/volume keys do nothing
    function automatic logic ignored_code(input logic [7:0] sc);
        logic is_mod;
        logic is_vol;
        is_mod = (sc >= 8'd224) && (sc <= 8'd231);
        is_vol = (sc >= 8'd127) && (sc <= 8'd129);
        return is_mod || is_vol;
    endfunction

    function automatic logic [7:0] translate(input logic [7:0] sc);
        logic [7:0] code;
        if (sc < 8'(KEYMAP_SIZE))
        begin
            code = KEYMAP[sc[6:0]];
        end
        else
        begin
            code = 8'h00;
        end
        return code;
    endfunction

    function automatic logic [5:0] mag63(input logic signed [16:0] d);
        logic [16:0] m;
        m = d[16] ? 17'(-d) : 17'(d);
        return (m > 17'(MAG_LIMIT)) ? MAG_LIMIT : m[5:0];
    endfunction

endpackage

[sv/keyboard_queue_mouse_latch_device.sv]
// Keyboard queue and latched mouse word.
//
// Request channel (req_valid/req_stall): one beat carries a key event, a vblank
// mouse sample, a bus read or a bus write, selected by req_type. Response
// channel (rsp_valid/rsp_stall): exactly one beat per request, carrying
// read_data (0 except for bus reads) and overflow_beep (dropped key event).
//
// A request beat lands in an input register; the next edge at which the
// response register is free computes the result, updates the queue and
// mouse state and loads the response register. The key queue is a ring
// buffer whose head entry is kept in a registered read port, which lets one
// request be taken every cycle while rsp_stall does not hold a response.
//
// When rsp_stall holds a pending response, the input register keeps its beat
// and req_stall rises; nothing is lost and nothing is processed twice.
//
// Reset empties the queue and clears the last pointer position and the mouse
// word; queue contents are not cleared.
module keyboard_queue_mouse_latch_device #(
    parameter int QUEUE_DEPTH = kqml_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         req_type,
    input  logic [7:0]         scancode,
    input  logic [3:0]         key_mods,
    input  logic               mouse_locked,
    input  logic signed [15:0] pointer_x,
    input  logic signed [15:0] pointer_y,
    input  logic               left_button,
    input  logic               right_button,
    input  logic [8:0]         bus_address,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [7:0]         read_data,
    output logic               overflow_beep
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(2 * QUEUE_DEPTH);

    logic                in_valid_reg;
    kqml_pkg::req_kind_t kind_reg;
    logic [7:0]          scancode_reg;
    logic [3:0]          mods_reg;
    logic                locked_reg;
    logic [15:0]         px_reg;
    logic [15:0]         py_reg;
    logic                lb_reg;
    logic                rb_reg;
    logic [8:0]          addr_reg;

    logic [IW-1:0]       head_reg;
    logic [IW-1:0]       head_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [15:0]         last_x_reg;
    logic [15:0]         last_x_next;
    logic [15:0]         last_y_reg;
    logic [15:0]         last_y_next;
    logic [15:0]         mouse_reg;
    logic [15:0]         mouse_next;
    logic [7:0]          front_reg;

    logic                rsp_valid_reg;
    logic [7:0]          data_reg;
    logic [7:0]          data_next;
    logic                beep_reg;
    logic                beep_next;

    logic [7:0]          mem [QUEUE_DEPTH];

    logic                fire;
    logic                accept;
    logic                we;
    logic [7:0]          wdata;
    logic [SW-1:0]       tail_sum;
    logic [IW-1:0]       tail;
    logic signed [16:0]  dx;
    logic signed [16:0]  dy;

    assign fire      = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !fire;
    assign accept    = req_valid && !req_stall;

    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : IW'(tail_sum);

    assign dx = {px_reg[15], px_reg} - {last_x_reg[15], last_x_reg};
    assign dy = {py_reg[15], py_reg} - {last_y_reg[15], last_y_reg};

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        mouse_next  = mouse_reg;
        data_next   = 8'h00;
        beep_next   = 1'b0;
        we          = 1'b0;
        wdata       = mods_reg[3] ? 8'h00 : kqml_pkg::translate(scancode_reg);
        if (fire)
        begin
            case (kind_reg)
                kqml_pkg::REQ_KEY:
                begin
                    if (!kqml_pkg::ignored_code(scancode_reg))
                    begin
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            beep_next = 1'b1;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                kqml_pkg::REQ_VBLANK:
                begin
                    if (!locked_reg)
                    begin
                        last_x_next = 16'h0000;
                        last_y_next = 16'h0000;
                    end
                    else
                    begin
                        mouse_next  = {rb_reg, lb_reg, dy[16], kqml_pkg::mag63(dy),
                                       dx[16], kqml_pkg::mag63(dx)};
                        last_x_next = px_reg;
                        last_y_next = py_reg;
                    end
                end
                kqml_pkg::REQ_READ:
                begin
                    if (addr_reg == kqml_pkg::ADDR_POP)
                    begin
                        if (count_reg != '0)
                        begin
                            data_next  = front_reg;
                            head_next  = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (addr_reg == kqml_pkg::ADDR_MOUSE_HI)
                    begin
                        data_next = mouse_reg[15:8];
                    end
                    else if (addr_reg == kqml_pkg::ADDR_MOUSE_LO)
                    begin
                        data_next = mouse_reg[7:0];
                    end
                    else if (addr_reg >= kqml_pkg::ADDR_KEYS_LO &&
                             addr_reg <= kqml_pkg::ADDR_KEYS_HI)
                    begin
                        count_next = '0;
                    end
                end
                kqml_pkg::REQ_WRITE:
                begin
                    if (addr_reg == kqml_pkg::ADDR_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            last_x_reg    <= 16'h0000;
            last_y_reg    <= 16'h0000;
            mouse_reg     <= 16'h0000;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            head_reg   <= head_next;
            count_reg  <= count_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            mouse_reg  <= mouse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kqml_pkg::req_kind_t'(req_type);
            scancode_reg <= scancode;
            mods_reg     <= key_mods;
            locked_reg   <= mouse_locked;
            px_reg       <= pointer_x;
            py_reg       <= pointer_y;
            lb_reg       <= left_button;
            rb_reg       <= right_button;
            addr_reg     <= bus_address;
        end
        if (fire)
        begin
            data_reg <= data_next;
            beep_reg <= beep_next;
        end
    end

    // key queue; front_reg tracks the entry at the head, with write bypass
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[tail] <= wdata;
        end
        if (we && (tail == head_next))
        begin
            front_reg <= wdata;
        end
        else
        begin
            front_reg <= mem[head_next];
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign read_data     = data_reg;
    assign overflow_beep = beep_reg;

endmodule

[tb/sv/keyboard_queue_mouse_latch_device_tb.sv]
`timescale 1ns / 100ps

module keyboard_queue_mouse_latch_device_tb;

    localparam int ITEM_TARGET    = 1950;
    localparam int HOLD_START     = 1500;
    localparam int HOLD_LEN       = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        kqml_pkg::req_kind_t kind;
        logic [7:0]          sc;
        logic [3:0]          mods;
        logic                locked;
        logic signed [15:0]  px;
        logic signed [15:0]  py;
        logic                lb;
        logic                rb;
        logic [8:0]          addr;
    } kb_req_t;

    typedef struct {
        logic [7:0] data;
        logic       beep;
    } kb_rsp_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         req_type = 2'd0;
    logic [7:0]         scancode = 8'd0;
    logic [3:0]         key_mods = 4'd0;
    logic               mouse_locked = 1'b0;
    logic signed [15:0] pointer_x = 16'sd0;
    logic signed [15:0] pointer_y = 16'sd0;
    logic               left_button = 1'b0;
    logic               right_button = 1'b0;
    logic [8:0]         bus_address = 9'd0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [7:0]         read_data;
    logic               overflow_beep;

    kb_req_t            pending_reqs[$];
    kb_rsp_t            rsp_expect[$];
    logic [7:0]         key_fifo[$];
    logic signed [15:0] seen_x = 16'sd0;
    logic signed [15:0] seen_y = 16'sd0;
    logic [15:0]        latched_word = 16'h0000;
    kb_req_t            cur_req;
    int                 live_items = 0;
    int                 total_items = 0;
    int                 accepted_items = 0;
    int                 mismatch_count = 0;
    int                 burst_left = 8;
    int                 gap_left = 0;
    int                 cycle_no = 0;
    int                 rx_mode = 0;
    int                 rx_left = 0;
    int                 idle_cycles = 0;

    keyboard_queue_mouse_latch_device uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .scancode      (scancode),
        .key_mods      (key_mods),
        .mouse_locked  (mouse_locked),
        .pointer_x     (pointer_x),
        .pointer_y     (pointer_y),
        .left_button   (left_button),
        .right_button  (right_button),
        .bus_address   (bus_address),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .read_data     (read_data),
        .overflow_beep (overflow_beep)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic is_dead_key(input logic [7:0] sc);
        return (sc >= 8'd224 && sc <= 8'd231) || (sc >= 8'd127 && sc <= 8'd129);
    endfunction

    function automatic logic [5:0] clip63(input int d);
        int m;
        m = (d < 0) ? -d : d;
        return (m > 63) ? 6'd63 : 6'(m);
    endfunction

    function automatic kb_req_t rand_req();
        kb_req_t r;
        r.kind   = kqml_pkg::req_kind_t'($urandom_range(0, 3));
        r.sc     = 8'($urandom);
        r.mods   = 4'($urandom);
        r.locked = 1'($urandom);
        r.px     = 16'($urandom);
        r.py     = 16'($urandom);
        r.lb     = 1'($urandom);
        r.rb     = 1'($urandom);
        r.addr   = 9'($urandom);
        return r;
    endfunction

    function automatic kb_req_t key_req(input logic [7:0] sc, input logic [3:0] mods);
        kb_req_t r;
        r      = rand_req();
        r.kind = kqml_pkg::REQ_KEY;
        r.sc   = sc;
        r.mods = mods;
        return r;
    endfunction

    function automatic kb_req_t bus_req(input kqml_pkg::req_kind_t kind,
                                        input logic [8:0] addr);
        kb_req_t r;
        r      = rand_req();
        r.kind = kind;
        r.addr = addr;
        return r;
    endfunction

    function automatic kb_req_t mouse_req(input logic locked, input logic signed [15:0] px,
                                          input logic signed [15:0] py, input logic lb,
                                          input logic rb);
        kb_req_t r;
        r        = rand_req();
        r.kind   = kqml_pkg::REQ_VBLANK;
        r.locked = locked;
        r.px     = px;
        r.py     = py;
        r.lb     = lb;
        r.rb     = rb;
        return r;
    endfunction

    task automatic enqueue(input kb_req_t r);
        pending_reqs.push_back(r);
        total_items++;
        if (!((r.kind == kqml_pkg::REQ_KEY && is_dead_key(r.sc)) ||
              (r.kind == kqml_pkg::REQ_WRITE && r.addr != kqml_pkg::ADDR_CLEAR)))
        begin
            live_items++;
        end
    endtask

    task automatic predict_response(input kb_req_t r);
        kb_rsp_t    e;
        logic [7:0] code;
        int         dx;
        int         dy;
        e.data = 8'h00;
        e.beep = 1'b0;
        case (r.kind)
            kqml_pkg::REQ_KEY:
            begin
                if (!is_dead_key(r.sc))
                begin
                    if (key_fifo.size() >= kqml_pkg::QUEUE_DEPTH)
                    begin
                        e.beep = 1'b1;
                    end
                    else
                    begin
                        code = (r.sc < kqml_pkg::KEYMAP_SIZE) ? kqml_pkg::KEYMAP[r.sc[6:0]]
                                                              : 8'h00;
                        if (r.mods[3])
                        begin
                            code = 8'h00;
                        end
                        key_fifo.push_back(code);
                    end
                end
            end
            kqml_pkg::REQ_VBLANK:
            begin
                if (!r.locked)
                begin
                    seen_x = 16'sd0;
                    seen_y = 16'sd0;
                end
                else
                begin
                    dx = int'(r.px) - int'(seen_x);
                    dy = int'(r.py) - int'(seen_y);
                    latched_word = {r.rb, r.lb, dy < 0, clip63(dy), dx < 0, clip63(dx)};
                    seen_x = r.px;
                    seen_y = r.py;
                end
            end
            kqml_pkg::REQ_READ:
            begin
                if (r.addr == kqml_pkg::ADDR_POP)
                begin
                    if (key_fifo.size() > 0)
                    begin
                        e.data = key_fifo.pop_front();
                    end
                end
                else if (r.addr == kqml_pkg::ADDR_MOUSE_HI)
                begin
                    e.data = latched_word[15:8];
                end
                else if (r.addr == kqml_pkg::ADDR_MOUSE_LO)
                begin
                    e.data = latched_word[7:0];
                end
                else if (r.addr >= kqml_pkg::ADDR_KEYS_LO && r.addr <= kqml_pkg::ADDR_KEYS_HI)
                begin
                    key_fifo.delete();
                end
            end
            default:
            begin
                if (r.addr == kqml_pkg::ADDR_CLEAR)
                begin
                    key_fifo.delete();
                end
            end
        endcase
        rsp_expect.push_back(e);
    endtask

    // sender: bursts of beats with random gaps, payload held while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_response(cur_req);
                accepted_items++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req_valid    <= 1'b1;
                    req_type     <= cur_req.kind;
                    scancode     <= cur_req.sc;
                    key_mods     <= cur_req.mods;
                    mouse_locked <= cur_req.locked;
                    pointer_x    <= cur_req.px;
                    pointer_y    <= cur_req.py;
                    left_button  <= cur_req.lb;
                    right_button <= cur_req.rb;
                    bus_address  <= cur_req.addr;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern in stretches, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            cycle_no++;
            if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_LEN)
            begin
                rsp_stall <= 1'b1;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(10, 80);
                end
                else
                begin
                    rx_left--;
                end
                case (rx_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    default: rsp_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        kb_rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_expect.size() == 0)
            begin
                $display("%0t: unexpected response read_data %h overflow_beep %b",
                         $time, read_data, overflow_beep);
                mismatch_count++;
            end
            else
            begin
                e = rsp_expect.pop_front();
                if (read_data !== e.data)
                begin
                    $display("%0t: read_data expected %h got %h", $time, e.data, read_data);
                    mismatch_count++;
                end
                if (overflow_beep !== e.beep)
                begin
                    $display("%0t: overflow_beep expected %b got %b",
                             $time, e.beep, overflow_beep);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                $display("keyboard_queue_mouse_latch_device_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [15:0] ptr_x;
        logic signed [15:0] ptr_y;
        kb_req_t            r;
        int                 n;

        ptr_x = 16'sd0;
        ptr_y = 16'sd0;

        // directed: empty pop, keymap ends, out-of-map and ignored codes, right ctrl
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_POP));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_HI));
        enqueue(key_req(8'd4, 4'h0));
        enqueue(key_req(8'd99, 4'h7));
        enqueue(key_req(8'd73, 4'h0));
        enqueue(key_req(8'd100, 4'h1));
        enqueue(key_req(8'd255, 4'h0));
        enqueue(key_req(8'd30, 4'hF));
        enqueue(key_req(8'd224, 4'h0));
        enqueue(key_req(8'd231, 4'h8));
        enqueue(key_req(8'd127, 4'h0));
        enqueue(key_req(8'd129, 4'h0));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_POP));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_POP));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_POP));
        // mouse extremes, then unlocked sample
        enqueue(mouse_req(1'b1, 16'sh7FFF, -16'sh8000, 1'b1, 1'b1));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_HI));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_LO));
        enqueue(mouse_req(1'b1, -16'sh8000, 16'sh7FFF, 1'b0, 1'b0));
        enqueue(mouse_req(1'b0, 16'sh0000, 16'sh0000, 1'b1, 1'b0));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_LO));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_KEYS_LO));
        enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_KEYS_HI));
        enqueue(bus_req(kqml_pkg::REQ_READ, 9'h140));
        enqueue(bus_req(kqml_pkg::REQ_READ, 9'h1FF));
        enqueue(bus_req(kqml_pkg::REQ_WRITE, 9'h1FF));
        enqueue(bus_req(kqml_pkg::REQ_WRITE, kqml_pkg::ADDR_CLEAR));

        while (live_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // typing: long runs overflow the queue
                    n = $urandom_range(1, 40);
                    repeat (n)
                    begin
                        r = rand_req();
                        r.kind = kqml_pkg::REQ_KEY;
                        if ($urandom_range(0, 3) != 0)
                        begin
                            r.sc = 8'($urandom_range(0, kqml_pkg::KEYMAP_SIZE - 1));
                        end
                        r.mods = ($urandom_range(0, 4) == 0) ? (r.mods | 4'h8) : (r.mods & 4'h7);
                        enqueue(r);
                    end
                end
                3, 4:
                begin
                    n = $urandom_range(1, 36);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_HI));
                        end
                        else
                        begin
                            enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_POP));
                        end
                    end
                end
                5, 6:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            ptr_x = 16'sd0;
                            ptr_y = 16'sd0;
                            enqueue(mouse_req(1'b0, 16'($urandom), 16'($urandom),
                                              1'($urandom), 1'($urandom)));
                        end
                        else
                        begin
                            if ($urandom_range(0, 9) == 0)
                            begin
                                ptr_x = 16'($urandom);
                                ptr_y = 16'($urandom);
                            end
                            else
                            begin
                                ptr_x += 16'($urandom_range(0, 200) - 100);
                                ptr_y += 16'($urandom_range(0, 200) - 100);
                            end
                            enqueue(mouse_req(1'b1, ptr_x, ptr_y, 1'($urandom), 1'($urandom)));
                        end
                    end
                    enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_HI));
                    enqueue(bus_req(kqml_pkg::REQ_READ, kqml_pkg::ADDR_MOUSE_LO));
                end
                7:
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        enqueue(bus_req(kqml_pkg::REQ_WRITE, kqml_pkg::ADDR_CLEAR));
                    end
                    else
                    begin
                        enqueue(bus_req(kqml_pkg::REQ_READ,
                                        9'($urandom_range(kqml_pkg::ADDR_KEYS_LO,
                                                          kqml_pkg::ADDR_KEYS_HI))));
                    end
                end
                default:
                begin
                    n = $urandom_range(1, 8);
                    repeat (n) enqueue(rand_req());
                end
            endcase
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items || rsp_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("keyboard_queue_mouse_latch_device_tb: PASS");
        end
        else
        begin
            $display("keyboard_queue_mouse_latch_device_tb: FAIL");
        end
        $finish;
    end

endmodule
